// File: design/cdte_pkg.sv
// Shared types, constants and calendar helper functions for the civil date to epoch days unit.
`timescale 1ns / 1ps

package cdte_pkg;

  // Field widths
  localparam int unsigned YEAR_BITS  = 16;
  localparam int unsigned MONTH_BITS = 4;
  localparam int unsigned DAY_BITS   = 5;
  localparam int unsigned EPOCH_BITS = 25;
  localparam int unsigned WDAY_BITS  = 3;
  localparam int unsigned YDAY_BITS  = 9;
  localparam int unsigned MLEN_BITS  = 5;

  // Internal widths: year within an era (0..399), day within an era (0..146096)
  localparam int unsigned YOE_BITS = 9;
  localparam int unsigned DOE_BITS = 18;

  // Calendar constants
  localparam int unsigned YEARS_PER_ERA = 400;
  localparam int unsigned DAYS_PER_ERA  = 146097;
  localparam int unsigned EPOCH_OFFSET  = 719468;  // 0000-03-01 to 1970-01-01
  localparam int unsigned JAN_DOY       = 306;     // March-based day of Jan 1
  localparam int unsigned MARCH_YDAY    = 59;      // Jan + Feb of a common year
  localparam int unsigned EPOCH_WDAY    = 3;       // aligns day-of-era with Sunday = 0

  typedef enum logic [1:0] {
    STATUS_OK        = 2'd0,
    STATUS_BAD_MONTH = 2'd1,
    STATUS_BAD_DAY   = 2'd2
  } status_e;

  typedef struct packed {
    logic signed [YEAR_BITS-1:0] year_in;
    logic [MONTH_BITS-1:0]       month_in;
    logic [DAY_BITS-1:0]         day_in;
  } date_t;

  typedef struct packed {
    logic signed [EPOCH_BITS-1:0] epoch_days;
    logic [WDAY_BITS-1:0]         weekday;
    logic [YDAY_BITS-1:0]         year_day;
    logic [MLEN_BITS-1:0]         month_length;
    status_e                      status;
  } result_t;

  // Length of a month in a common year, zero for an invalid month number
  function automatic logic [MLEN_BITS-1:0] month_days(input logic [MONTH_BITS-1:0] month);
    logic [MLEN_BITS-1:0] len;
    if (month inside {4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12}) begin
      len = 5'd31;
    end else if (month inside {4'd4, 4'd6, 4'd9, 4'd11}) begin
      len = 5'd30;
    end else if (month == 4'd2) begin
      len = 5'd28;
    end else begin
      len = 5'd0;
    end
    return len;
  endfunction

  // First day of each month in a year that starts on March 1
  function automatic logic [YDAY_BITS-1:0] march_day(input logic [MONTH_BITS-1:0] month);
    logic [YDAY_BITS-1:0] base;
    case (month)
      4'd3:    base = 9'd0;
      4'd4:    base = 9'd31;
      4'd5:    base = 9'd61;
      4'd6:    base = 9'd92;
      4'd7:    base = 9'd122;
      4'd8:    base = 9'd153;
      4'd9:    base = 9'd184;
      4'd10:   base = 9'd214;
      4'd11:   base = 9'd245;
      4'd12:   base = 9'd275;
      4'd1:    base = 9'd306;
      4'd2:    base = 9'd337;
      default: base = 9'd0;
    endcase
    return base;
  endfunction

  // Leap rule on a year's position in its era, 0..400 (400 wraps to 0)
  function automatic logic leap_in_era(input logic [YOE_BITS:0] pos);
    return (pos[1:0] == 2'b00) && !(pos == 10'd100 || pos == 10'd200 || pos == 10'd300);
  endfunction

  // Number of whole centuries in a year of era, 0..3
  function automatic logic [1:0] centuries(input logic [YOE_BITS-1:0] yoe);
    logic [1:0] c;
    if (yoe >= 9'd300) begin
      c = 2'd3;
    end else if (yoe >= 9'd200) begin
      c = 2'd2;
    end else if (yoe >= 9'd100) begin
      c = 2'd1;
    end else begin
      c = 2'd0;
    end
    return c;
  endfunction

endpackage

// File: design/cdte_div400.sv
// Two-stage floor division and remainder of an unsigned value by 400.
`timescale 1ns / 1ps

module cdte_div400 #(
  parameter int unsigned DividendBits = cdte_pkg::YEAR_BITS + 1,
  parameter int unsigned QuotientBits = DividendBits - 8
) (
  input  logic                             clk_i,
  input  logic [DividendBits-1:0]          dividend_i,
  output logic [QuotientBits-1:0]          quotient_o,
  output logic [cdte_pkg::YOE_BITS-1:0]    remainder_o
);
  import cdte_pkg::*;

  // x / 400 = (x >> 4) / 25; the /25 is an exact multiply by a rounded-up reciprocal
  localparam int unsigned ShiftedBits = DividendBits - 4;
  localparam int unsigned RecipShift  = ShiftedBits + 5;
  localparam int unsigned RecipBits   = RecipShift - 4;
  localparam int unsigned ProdBits    = ShiftedBits + RecipBits;
  localparam longint unsigned RecipVal = ((64'd1 << RecipShift) + 64'd24) / 64'd25;
  localparam logic [RecipBits-1:0]    Recip   = RecipBits'(RecipVal);
  localparam logic [DividendBits-1:0] Divisor = DividendBits'(YEARS_PER_ERA);

  logic [ShiftedBits-1:0]  shifted;
  logic [ProdBits-1:0]     prod;
  logic [QuotientBits-1:0] quot_q;
  logic [DividendBits-1:0] dividend_q;
  logic [DividendBits-1:0] scaled;
  logic [QuotientBits-1:0] quot2_q;
  logic [YOE_BITS-1:0]     rem_q;

  // Stage 1: reciprocal multiply
  assign shifted = dividend_i[DividendBits-1:4];
  assign prod    = ProdBits'(shifted) * ProdBits'(Recip);

  always_ff @(posedge clk_i) begin
    quot_q     <= prod[RecipShift +: QuotientBits];
    dividend_q <= dividend_i;
  end

  // Stage 2: remainder by back-multiply
  assign scaled = DividendBits'(quot_q) * Divisor;

  always_ff @(posedge clk_i) begin
    quot2_q <= quot_q;
    rem_q   <= YOE_BITS'(dividend_q - scaled);
  end

  assign quotient_o  = quot2_q;
  assign remainder_o = rem_q;

endmodule

// File: design/civil_date_to_epoch_days_unit.sv
// Top level: proleptic Gregorian date to days since 1970-01-01, weekday, day of year.
`timescale 1ns / 1ps

// Converts one date per clock cycle. A transaction is taken at each rising edge where
// start is high and busy is low; busy stays low, so a new date may be given every cycle.
// The result for a date is on result_o, with done_o high, for exactly one cycle;
// the receiver cannot hold it off. The result passes through the input register, the two
// stages of the divide-by-400 unit that splits the year into era and year of era, and the
// stage that multiplies out the era's days before the result register. Results keep the
// order of the dates. An invalid month or day gives a nonzero status and zero date fields.

module civil_date_to_epoch_days_unit (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start,
  output logic              busy,
  input  cdte_pkg::date_t   date_i,
  output logic              done_o,
  output cdte_pkg::result_t result_o
);
  import cdte_pkg::*;

  // Years are biased by whole eras so the divider sees a nonnegative value
  localparam int unsigned YearW = YEAR_BITS + 1;
  localparam int unsigned QuotW = YEAR_BITS - 7;
  localparam int unsigned ExtW  = YEAR_BITS + 2;
  localparam longint unsigned OfsEras  = ((64'd1 << (YEAR_BITS - 1)) + 64'd400) / 64'd400;
  localparam longint unsigned OfsYears = OfsEras * 64'd400;
  localparam logic [EPOCH_BITS-1:0] ZBias =
    EPOCH_BITS'(OfsEras * longint'(DAYS_PER_ERA) + longint'(EPOCH_OFFSET));
  localparam int unsigned Digits = DOE_BITS / 3;

  logic accept;

  // Stage 0: input register
  date_t date_q;
  logic  in_valid_q;

  // Stages 1 and 2: control alongside the divider
  logic [MONTH_BITS-1:0] s1_month_q, s2_month_q;
  logic [DAY_BITS-1:0]   s1_day_q, s2_day_q;
  logic                  s1_valid_q, s2_valid_q;

  logic signed [ExtW-1:0] year_ext;
  logic [YearW-1:0]       year_biased;
  logic [QuotW-1:0]       div_quot;
  logic [YOE_BITS-1:0]    div_rem;

  // Stage 3 signals
  logic                  early_c;
  logic                  month_ok_c;
  logic                  leap_date_c;
  logic                  leap_y_c;
  logic [MLEN_BITS-1:0]  mlen_c;
  status_e               status_c;
  logic [YDAY_BITS-1:0]  doy_c;
  logic [DOE_BITS-1:0]   doe_c;
  logic [YDAY_BITS-1:0]  yday_c;
  logic [EPOCH_BITS-1:0] era_days_c;

  logic [EPOCH_BITS-1:0] s3_era_days_q;
  logic [DOE_BITS-1:0]   s3_doe_q;
  logic [YDAY_BITS-1:0]  s3_yday_q;
  logic [MLEN_BITS-1:0]  s3_mlen_q;
  status_e               s3_status_q;
  logic                  s3_valid_q;

  // Stage 4 signals
  logic [EPOCH_BITS-1:0] z_c;
  logic [DOE_BITS-1:0]   wd_src;
  logic [5:0]            digit_sum;
  logic [3:0]            fold;
  logic [WDAY_BITS-1:0]  weekday_c;

  result_t out_q;
  logic    done_q;

  assign busy   = 1'b0;
  assign accept = start && !busy;

  // Valid chain
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
      s1_valid_q <= 1'b0;
      s2_valid_q <= 1'b0;
      s3_valid_q <= 1'b0;
      done_q     <= 1'b0;
    end else begin
      in_valid_q <= accept;
      s1_valid_q <= in_valid_q;
      s2_valid_q <= s1_valid_q;
      s3_valid_q <= s2_valid_q;
      done_q     <= s3_valid_q;
    end
  end

  // Input register
  always_ff @(posedge clk_i) begin
    if (accept) begin
      date_q <= date_i;
    end
  end

  // Year of a March-based calendar, biased positive
  assign year_ext    = ExtW'(date_q.year_in) - ExtW'(date_q.month_in < 4'd3);
  assign year_biased = YearW'(year_ext + ExtW'(OfsYears));

  cdte_div400 #(
    .DividendBits(YearW),
    .QuotientBits(QuotW)
  ) u_div400 (
    .clk_i      (clk_i),
    .dividend_i (year_biased),
    .quotient_o (div_quot),
    .remainder_o(div_rem)
  );

  always_ff @(posedge clk_i) begin
    s1_month_q <= date_q.month_in;
    s1_day_q   <= date_q.day_in;
    s2_month_q <= s1_month_q;
    s2_day_q   <= s1_day_q;
  end

  // Stage 3: checks, day of era, day of year, era days
  assign early_c     = s2_month_q < 4'd3;
  assign month_ok_c  = s2_month_q inside {[4'd1:4'd12]};
  assign leap_y_c    = leap_in_era({1'b0, div_rem});
  assign leap_date_c = leap_in_era((YOE_BITS + 1)'(div_rem) + (YOE_BITS + 1)'(early_c));
  assign mlen_c      = month_days(s2_month_q)
                     + MLEN_BITS'((s2_month_q == 4'd2) && leap_date_c);

  always_comb begin
    if (!month_ok_c) begin
      status_c = STATUS_BAD_MONTH;
    end else if (s2_day_q == '0 || s2_day_q > mlen_c) begin
      status_c = STATUS_BAD_DAY;
    end else begin
      status_c = STATUS_OK;
    end
  end

  assign doy_c = march_day(s2_month_q) + YDAY_BITS'(s2_day_q) - YDAY_BITS'(1);
  assign doe_c = DOE_BITS'(div_rem) * DOE_BITS'(365) + DOE_BITS'(div_rem[YOE_BITS-1:2])
               - DOE_BITS'(centuries(div_rem)) + DOE_BITS'(doy_c);
  assign yday_c = (doy_c >= YDAY_BITS'(JAN_DOY)) ? doy_c - YDAY_BITS'(JAN_DOY)
                : doy_c + YDAY_BITS'(MARCH_YDAY) + YDAY_BITS'(leap_y_c);
  assign era_days_c = EPOCH_BITS'(EPOCH_BITS'(div_quot) * EPOCH_BITS'(DAYS_PER_ERA));

  always_ff @(posedge clk_i) begin
    s3_era_days_q <= era_days_c;
    s3_doe_q      <= doe_c;
    s3_yday_q     <= yday_c;
    s3_mlen_q     <= mlen_c;
    s3_status_q   <= status_c;
  end

  // Stage 4: day count and weekday (8 = 1 mod 7, so octal digits sum mod 7)
  assign z_c    = s3_era_days_q + EPOCH_BITS'(s3_doe_q) - ZBias;
  assign wd_src = s3_doe_q + DOE_BITS'(EPOCH_WDAY);

  always_comb begin
    digit_sum = '0;
    for (int i = 0; i < Digits; i++) begin
      digit_sum = digit_sum + 6'(wd_src[3*i +: 3]);
    end
  end

  assign fold      = 4'(digit_sum[5:3]) + 4'(digit_sum[2:0]);
  assign weekday_c = (fold >= 4'd7) ? WDAY_BITS'(fold - 4'd7) : WDAY_BITS'(fold);

  // Result register, date fields cleared on a failed check
  always_ff @(posedge clk_i) begin
    out_q.status       <= s3_status_q;
    out_q.month_length <= s3_mlen_q;
    if (s3_status_q == STATUS_OK) begin
      out_q.epoch_days <= $signed(z_c);
      out_q.weekday    <= weekday_c;
      out_q.year_day   <= s3_yday_q;
    end else begin
      out_q.epoch_days <= '0;
      out_q.weekday    <= '0;
      out_q.year_day   <= '0;
    end
  end

  assign done_o   = done_q;
  assign result_o = out_q;

`ifndef SYNTHESIS
  // Every taken date yields its result strobe on done_o
  a_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |-> ##5 done_o)
    else $error("result strobe missing after accepted transaction");

  // The divider leaves a year of era below 400
  a_yoe_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s2_valid_q |-> div_rem < 9'd400)
    else $error("year of era out of range");

  // Failed checks clear the date fields
  a_err_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && result_o.status != STATUS_OK |->
      result_o.epoch_days == '0 && result_o.weekday == '0 && result_o.year_day == '0)
    else $error("date fields not cleared on error");

  // Month length agrees with the status
  a_mlen: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> (result_o.status == STATUS_BAD_MONTH) == (result_o.month_length == '0))
    else $error("month length inconsistent with status");

  // Good results stay within calendar ranges
  a_ok_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && result_o.status == STATUS_OK |->
      result_o.weekday <= 3'd6 && result_o.year_day <= 9'd365
      && result_o.month_length >= 5'd28)
    else $error("result field out of calendar range");
`endif

endmodule

// File: tb/testbench.sv
// Self-checking testbench for the civil date to epoch days unit.
`timescale 1ns / 1ps

module testbench;
  import cdte_pkg::*;

  localparam int unsigned CYCLE_LIMIT   = 200000;
  localparam int unsigned DRAIN_CYCLES  = 12;
  localparam int unsigned RANDOM_DATES  = 450;

  // Tracks dates in flight and checks each converted result in order
  class epoch_scoreboard;
    result_t pending_conversions[$];
    int unsigned errors;

    static function automatic bit is_leap_year(longint yr);
      return (yr % 4 == 0) && ((yr % 100 != 0) || (yr % 400 == 0));
    endfunction

    static function automatic int unsigned month_len(logic [MONTH_BITS-1:0] mon, longint yr);
      int unsigned len;
      case (mon)
        4'd2:                      len = is_leap_year(yr) ? 29 : 28;
        4'd4, 4'd6, 4'd9, 4'd11:   len = 30;
        4'd1, 4'd3, 4'd5, 4'd7,
        4'd8, 4'd10, 4'd12:        len = 31;
        default:                   len = 0;
      endcase
      return len;
    endfunction

    // Days since 1970-01-01 via March-based years grouped into 400-year eras
    static function automatic result_t convert_date(date_t d);
      result_t res;
      longint  yr, y, era, yoe, mp, doy, doe, z, r;
      int unsigned len;
      res = '0;
      res.status = STATUS_OK;
      yr = $signed(d.year_in);
      if (d.month_in < 1 || d.month_in > 12) begin
        res.status = STATUS_BAD_MONTH;
        return res;
      end
      len = month_len(d.month_in, yr);
      res.month_length = len[MLEN_BITS-1:0];
      if (d.day_in < 1 || d.day_in > len) begin
        res.status = STATUS_BAD_DAY;
        return res;
      end
      y   = yr - ((d.month_in <= 2) ? 1 : 0);
      era = ((y >= 0) ? y : y - 399) / 400;
      yoe = y - era * 400;
      mp  = (d.month_in > 2) ? d.month_in - 3 : d.month_in + 9;
      doy = (153 * mp + 2) / 5 + d.day_in - 1;
      doe = yoe * 365 + yoe / 4 - yoe / 100 + doy;
      z   = era * 146097 + doe - 719468;
      r   = z % 7;
      if (r < 0) begin
        r += 7;
      end
      res.epoch_days = z[EPOCH_BITS-1:0];
      res.weekday    = WDAY_BITS'((r + 4) % 7);
      if (doy > 305) begin
        res.year_day = YDAY_BITS'(doy - 306);
      end else begin
        res.year_day = YDAY_BITS'(doy + 59 + (is_leap_year(y) ? 1 : 0));
      end
      return res;
    endfunction

    function void note_date(date_t d);
      pending_conversions.push_back(convert_date(d));
    endfunction

    function void report_field(string name, longint exp_val, longint act_val);
      if (exp_val != act_val) begin
        errors++;
        $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, exp_val, act_val);
      end
    endfunction

    function void check_result(result_t act);
      result_t exp_res;
      if (pending_conversions.size() == 0) begin
        errors++;
        $display("%0t: unexpected result, expected none, actual %p", $time, act);
        return;
      end
      exp_res = pending_conversions.pop_front();
      report_field("epoch_days", $signed(exp_res.epoch_days), $signed(act.epoch_days));
      report_field("weekday", exp_res.weekday, act.weekday);
      report_field("year_day", exp_res.year_day, act.year_day);
      report_field("month_length", exp_res.month_length, act.month_length);
      report_field("status", exp_res.status, act.status);
    endfunction
  endclass

  logic    clk_i;
  logic    rst_ni;
  logic    start;
  logic    busy;
  date_t   date_i;
  logic    done_o;
  result_t result_o;

  epoch_scoreboard scoreboard = new();
  int unsigned     cycle_count = 0;
  int unsigned     send_idle_pct;

  civil_date_to_epoch_days_unit u_dut (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start   (start),
    .busy    (busy),
    .date_i  (date_i),
    .done_o  (done_o),
    .result_o(result_o)
  );

  // Clock
  initial clk_i = 1'b0;
  always #5 clk_i = ~clk_i;

  // Result monitor
  always @(posedge clk_i) begin
    if (rst_ni && done_o) begin
      scoreboard.check_result(result_o);
    end
  end

  // Watchdog
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  function automatic date_t make_date(int yr, int mon, int dd);
    date_t d;
    d.year_in  = YEAR_BITS'(yr);
    d.month_in = MONTH_BITS'(mon);
    d.day_in   = DAY_BITS'(dd);
    return d;
  endfunction

  // Mostly valid dates, biased toward the modern era and century years
  function automatic date_t random_date();
    date_t d;
    int    yr;
    int    sel;
    int unsigned len;
    sel = $urandom_range(99);
    if (sel < 35) begin
      yr = $signed(16'($urandom_range(65535)));
    end else if (sel < 70) begin
      yr = $urandom_range(2100, 1900);
    end else if (sel < 85) begin
      yr = 100 * ($signed($urandom_range(654)) - 327) + $signed($urandom_range(2)) - 1;
    end else begin
      yr = $signed($urandom_range(800)) - 400;
    end
    d.year_in = YEAR_BITS'(yr);
    if ($urandom_range(99) < 90) begin
      d.month_in = MONTH_BITS'($urandom_range(12, 1));
    end else begin
      sel = $urandom_range(3);
      d.month_in = (sel == 0) ? 4'd0 : MONTH_BITS'(12 + sel);
    end
    len = epoch_scoreboard::month_len(d.month_in, $signed(d.year_in));
    if (len == 0 || $urandom_range(99) < 88) begin
      d.day_in = DAY_BITS'((len == 0) ? $urandom_range(31) : $urandom_range(len, 1));
    end else if ($urandom_range(1) == 0 || len == 31) begin
      d.day_in = '0;
    end else begin
      d.day_in = DAY_BITS'($urandom_range(31, len + 1));
    end
    return d;
  endfunction

  // Present one date from a falling edge until the unit takes it
  task automatic send_date(date_t d);
    while ($urandom_range(99) < send_idle_pct) begin
      start <= 1'b0;
      @(negedge clk_i);
    end
    start  <= 1'b1;
    date_i <= d;
    do begin
      @(posedge clk_i);
    end while (busy);
    scoreboard.note_date(d);
    @(negedge clk_i);
  endtask

  initial begin
    date_t directed[$];
    int    phase;
    int    n;

    rst_ni        = 1'b0;
    start         = 1'b0;
    date_i        = '0;
    send_idle_pct = 12;

    repeat (8) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // Field extremes, epoch neighborhood, leap rules and each error case
    directed = '{
      make_date(1970, 1, 1),    make_date(1969, 12, 31),  make_date(2000, 2, 29),
      make_date(1900, 2, 29),   make_date(2100, 2, 28),   make_date(2024, 12, 31),
      make_date(2023, 12, 31),  make_date(0, 2, 29),      make_date(0, 3, 1),
      make_date(-1, 12, 31),    make_date(-4, 2, 29),     make_date(-100, 2, 29),
      make_date(-400, 3, 1),    make_date(-32768, 1, 1),  make_date(32767, 12, 31),
      make_date(-32768, 15, 31), make_date(2001, 0, 15),  make_date(2001, 13, 1),
      make_date(2001, 1, 0),    make_date(2001, 4, 31),   make_date(2001, 12, 31),
      make_date(1600, 2, 29),   make_date(1700, 2, 28),   make_date(-1, 1, 31)
    };
    foreach (directed[i]) begin
      send_date(directed[i]);
    end

    // Random dates in three pacing phases
    for (phase = 0; phase < 3; phase++) begin
      send_idle_pct = (phase == 0) ? 12 : (phase == 1) ? 67 : 0;
      for (n = 0; n < RANDOM_DATES / 3; n++) begin
        send_date(random_date());
      end
    end
    start <= 1'b0;

    // Drain outstanding conversions
    while (scoreboard.pending_conversions.size() != 0) begin
      @(posedge clk_i);
    end
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    if (scoreboard.errors == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
